[hdl/dual_modular_polynomial_hash_macros.svh]
// Assertion macros shared by the hash RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DUAL_MODULAR_POLYNOMIAL_HASH_MACROS_SVH
`define DUAL_MODULAR_POLYNOMIAL_HASH_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DMPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define DMPH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/dmph_pkg.sv]
// Shared types and constants for the dual modular polynomial hash.
// No dependencies; used by the interfaces and all modules.
package dmph_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned NUM_LANES = 2;

  // Byte folded for a separator word (':').
  localparam logic [BYTE_W-1:0] SEP_BYTE = 8'd58;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ONE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TWO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_TWO = 2'd3;

  localparam logic [HASH_W-1:0] BASE_ONE_RST    = 32'd131;
  localparam logic [HASH_W-1:0] MODULUS_ONE_RST = 32'd1000000007;
  localparam logic [HASH_W-1:0] BASE_TWO_RST    = 32'd137;
  localparam logic [HASH_W-1:0] MODULUS_TWO_RST = 32'd998244353;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Remainder steps per reduce cycle; 64-bit dividend
  localparam int unsigned RED_BITS = 2;
  localparam int unsigned RED_CYCLES = (2 * HASH_W) / RED_BITS;
  localparam int unsigned RED_CNT_W = $clog2(RED_CYCLES);

  typedef struct packed {
    logic [BYTE_W-1:0] c;       // byte to fold, separator already applied
    logic              start;   // clear hashes first
    logic              finish;  // emit hashes after fold
  } cmd_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][HASH_W-1:0] base;
    logic [NUM_LANES-1:0][HASH_W-1:0] modulus;  // 0 means 2^32
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_REDUCE,
    ST_WRITE
  } bk_state_e;

endpackage

[hdl/dmph_in_if.sv]
// Input word channel: one message byte plus control flags.
// Depends on dmph_pkg for field widths.
interface dmph_in_if;
  logic                       valid;
  logic                       ready;
  logic [dmph_pkg::BYTE_W-1:0] data_byte;
  logic                       is_separator;
  logic                       start_req;
  logic                       finish;

  modport source (output valid, data_byte, is_separator, start_req, finish, input ready);
  modport sink   (input valid, data_byte, is_separator, start_req, finish, output ready);
endinterface

[hdl/dmph_out_if.sv]
// Result word channel: both hash values.
// Depends on dmph_pkg for field widths.
interface dmph_out_if;
  logic                       valid;
  logic                       ready;
  logic [dmph_pkg::HASH_W-1:0] hash_one;
  logic [dmph_pkg::HASH_W-1:0] hash_two;

  modport source (output valid, hash_one, hash_two, input ready);
  modport sink   (input valid, hash_one, hash_two, output ready);
endinterface

[hdl/dual_modular_polynomial_hash.sv]
// Top level of the dual modular polynomial hash: config registers, front and back.
// Depends on dmph_pkg, dmph_in_if, dmph_out_if, dmph_front and dmph_back.
//
// Each input word folds one byte c into two 32-bit running hashes,
// h = (h * base + c) mod modulus, per hash with its own base and modulus register
// (a modulus of 0 acts as 2^32). start_req zeroes both hashes before the fold,
// is_separator folds ':' in place of data_byte, and finish emits one result word
// with both hashes after the fold. The back end takes one word at a time: the idle
// state forms the 32x32 products as it pops a command, the add state adds the byte,
// the reduce state runs a restoring remainder two dividend bits per cycle over the
// 64-bit sum (both hashes in parallel), and the write state commits the hashes. A
// two-entry command queue lets the input side accept words while the back end works,
// and the result register lets the back end start the next word while a result waits
// to be taken. Write the configuration only while the block is idle.
module dual_modular_polynomial_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dmph_in_if.sink                        in_i,
  dmph_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [dmph_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmph_pkg::HASH_W-1:0]    cfg_data_i
);
  import dmph_pkg::*;

  cfg_t cfg_q;
  cmd_t head;
  logic head_valid;
  logic pop;

  // configuration registers, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base[0]    <= BASE_ONE_RST;
      cfg_q.modulus[0] <= MODULUS_ONE_RST;
      cfg_q.base[1]    <= BASE_TWO_RST;
      cfg_q.modulus[1] <= MODULUS_TWO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_ONE:    cfg_q.base[0]    <= cfg_data_i;
        REG_MODULUS_ONE: cfg_q.modulus[0] <= cfg_data_i;
        REG_BASE_TWO:    cfg_q.base[1]    <= cfg_data_i;
        REG_MODULUS_TWO: cfg_q.modulus[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept, pick folded byte, queue
  dmph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  // back: modular multiply-add per lane, result register
  dmph_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[hdl/dmph_front.sv]
// Front end: accepts input words, resolves the folded byte, queues commands.
// Depends on dmph_pkg, dmph_in_if and the assertion macros.
`include "dual_modular_polynomial_hash_macros.svh"

module dmph_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dmph_in_if.sink        in_i,
  output dmph_pkg::cmd_t head_o,
  output logic           head_valid_o,
  input  logic           pop_i
);
  import dmph_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign in_i.ready   = (cnt_q != QCNT_W'(QDEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = q_mem[rd_ptr_q];

  always_comb begin
    cmd_in.c      = in_i.is_separator ? SEP_BYTE : in_i.data_byte;
    cmd_in.start  = in_i.start_req;
    cmd_in.finish = in_i.finish;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  `DMPH_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count above depth")

endmodule

[hdl/dmph_back.sv]
// Back end: per-lane multiply, add, 2-bit/cycle remainder, hash update, result reg.
// Depends on dmph_pkg, dmph_out_if and the assertion macros.
`include "dual_modular_polynomial_hash_macros.svh"

module dmph_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dmph_pkg::cfg_t cfg_i,
  input  dmph_pkg::cmd_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  dmph_out_if.source     out_o
);
  import dmph_pkg::*;

  bk_state_e state_q, state_d;

  logic [BYTE_W-1:0]    c_q;
  logic                 fin_q;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 wr_go;
  logic                 red_last;

  logic [NUM_LANES-1:0][2*HASH_W-1:0] prod_q, prod_d;
  logic [NUM_LANES-1:0][2*HASH_W-1:0] acc_q;
  logic [NUM_LANES-1:0][HASH_W-1:0]   lo_q;
  logic [NUM_LANES-1:0][HASH_W-1:0]   rem_q, rem_d;
  logic [NUM_LANES-1:0][HASH_W-1:0]   hash_q;
  logic [NUM_LANES-1:0][HASH_W-1:0]   res;
  logic [NUM_LANES-1:0][HASH_W-1:0]   out_h_q;

  // One restoring remainder step: shift in a dividend bit, subtract if it fits.
  function automatic logic [HASH_W-1:0] red_step(logic [HASH_W-1:0] r, logic b,
                                                 logic [HASH_W-1:0] m);
    logic [HASH_W:0] t;
    logic [HASH_W:0] d;
    t = {r, b};
    d = t - {1'b0, m};
    red_step = (t >= {1'b0, m}) ? d[HASH_W-1:0] : t[HASH_W-1:0];
  endfunction

  assign red_last = (cnt_q == RED_CNT_W'(RED_CYCLES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (head_valid_i) state_d = ST_ADD;
      ST_ADD:    state_d = ST_REDUCE;
      ST_REDUCE: if (red_last) state_d = ST_WRITE;
      ST_WRITE:  if (wr_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o = 1'b0;
    wr_go = 1'b0;
    case (state_q)
      ST_IDLE:  pop_o = head_valid_i;
      ST_WRITE: wr_go = !fin_q || !out_valid_q || out_o.ready;
      default: begin
        pop_o = 1'b0;
        wr_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d = (state_q == ST_REDUCE) ? cnt_q + 1'b1 : '0;
    out_valid_d = out_valid_q;
    if (wr_go && fin_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // lane datapath
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      prod_d[l] = 64'(head_i.start ? '0 : hash_q[l]) * 64'(cfg_i.base[l]);
      rem_d[l]  = red_step(red_step(rem_q[l], acc_q[l][2*HASH_W-1], cfg_i.modulus[l]),
                           acc_q[l][2*HASH_W-2], cfg_i.modulus[l]);
      res[l]    = (cfg_i.modulus[l] == '0) ? lo_q[l] : rem_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (wr_go) begin
        hash_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c_q    <= head_i.c;
      fin_q  <= head_i.finish;
      prod_q <= prod_d;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (state_q == ST_ADD) begin
        acc_q[l] <= prod_q[l] + 64'(c_q);
        lo_q[l]  <= prod_q[l][HASH_W-1:0] + HASH_W'(c_q);
        rem_q[l] <= '0;
      end else if (state_q == ST_REDUCE) begin
        acc_q[l] <= acc_q[l] << RED_BITS;
        rem_q[l] <= rem_d[l];
      end
    end
    if (wr_go && fin_q) begin
      out_h_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hash_one = out_h_q[0];
  assign out_o.hash_two = out_h_q[1];

  `DMPH_ASSERT(a_pop_idle, pop_o |-> (state_q == ST_IDLE), "command popped while busy")
  `DMPH_ASSERT(a_cnt_idle, (state_q != ST_REDUCE) |-> (cnt_q == '0), "reduce count not cleared")
  `DMPH_ASSERT(a_hash_hold, (state_q != ST_WRITE) |=> $stable(hash_q), "hash moved outside write")
  `DMPH_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(state_q == ST_WRITE), "result without write")

endmodule
